// ===== src/websocket_text_frame_unmasker_top_assert.svh =====
// Assertion macros shared by the frame unmasker modules.
`ifndef WEBSOCKET_TEXT_FRAME_UNMASKER_TOP_ASSERT_SVH
`define WEBSOCKET_TEXT_FRAME_UNMASKER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSTFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wstfu assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define WSTFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wstfu assertion failed");

`endif

// ===== src/wstfu_pkg.sv =====
// Package with the types and constants of the WebSocket text frame unmasker.
`timescale 1ns / 1ps

package wstfu_pkg;

    localparam int unsigned LEN_W = 7;

    localparam logic [7:0]       HDR_FIN       = 8'h80;
    localparam logic [3:0]       HDR_OPC_TEXT  = 4'h1;
    localparam logic [LEN_W-1:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [7:0]       MIN_BUFFER    = 8'd6;
    localparam logic [7:0]       DECIDE_POS    = MIN_BUFFER - 8'd1;
    localparam logic [7:0]       POS_MAX       = 8'hFF;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_EMPTY   = 3'd1,
        KIND_SHORT   = 3'd2,
        KIND_BADHDR  = 3'd3,
        KIND_EXTLEN  = 3'd4,
        KIND_TRUNC   = 3'd5
    } kind_t;

    // One classified result waiting for the back end.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] mask;
        logic       last;
    } entry_t;

endpackage

// ===== src/wstfu_front.sv =====
// Frame parser: tracks the byte position, captures header, length and mask, classifies bytes.
`timescale 1ns / 1ps

module wstfu_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                buffer_end,
    input  logic                push,
    output logic                full,
    input  logic                fifo_full,
    output logic                ent_valid,
    output wstfu_pkg::entry_t   ent
);

`include "websocket_text_frame_unmasker_top_assert.svh"

    logic [7:0]                  pos_reg, pos_next;
    logic                        hdr_ok_reg, hdr_ok_next;
    logic [wstfu_pkg::LEN_W-1:0] len_reg, len_next;
    logic [31:0]                 mask_reg, mask_next;
    logic                        done_reg, done_next;

    logic       accept;
    logic [1:0] lane;
    logic [7:0] mask_byte;
    logic [7:0] pay_count;
    logic       is_final;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    // Mask lane for both the key bytes (position minus 2) and payload (position minus 6).
    assign lane      = pos_reg[1:0] ^ 2'b10;
    assign mask_byte = mask_reg[{lane, 3'b000} +: 8];
    assign pay_count = pos_reg - wstfu_pkg::DECIDE_POS;
    assign is_final  = pay_count >= {1'b0, len_reg};

    always_comb
    begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        len_next    = len_reg;
        mask_next   = mask_reg;
        done_next   = done_reg;
        ent_valid   = 1'b0;
        ent.kind    = wstfu_pkg::KIND_PAYLOAD;
        ent.data    = 8'd0;
        ent.mask    = 8'd0;
        ent.last    = 1'b0;

        if (!done_reg)
        begin
            if (pos_reg == 8'd0)
            begin
                hdr_ok_next = ((rx_byte & wstfu_pkg::HDR_FIN) == wstfu_pkg::HDR_FIN) &&
                              (rx_byte[3:0] == wstfu_pkg::HDR_OPC_TEXT);
            end
            else if (pos_reg == 8'd1)
            begin
                len_next = rx_byte[wstfu_pkg::LEN_W-1:0];
            end
            else if (pos_reg < wstfu_pkg::MIN_BUFFER)
            begin
                mask_next[{lane, 3'b000} +: 8] = rx_byte;
            end

            if (pos_reg < wstfu_pkg::DECIDE_POS)
            begin
                if (buffer_end)
                begin
                    ent_valid = 1'b1;
                    ent.kind  = wstfu_pkg::KIND_SHORT;
                end
            end
            else if (pos_reg == wstfu_pkg::DECIDE_POS)
            begin
                priority if (!hdr_ok_reg)
                begin
                    ent_valid = 1'b1;
                    ent.kind  = wstfu_pkg::KIND_BADHDR;
                    done_next = 1'b1;
                end
                else if (len_reg > wstfu_pkg::LEN_MAX_SHORT)
                begin
                    ent_valid = 1'b1;
                    ent.kind  = wstfu_pkg::KIND_EXTLEN;
                    done_next = 1'b1;
                end
                else if (len_reg == '0)
                begin
                    ent_valid = 1'b1;
                    ent.kind  = wstfu_pkg::KIND_EMPTY;
                    done_next = 1'b1;
                end
                else if (buffer_end)
                begin
                    ent_valid = 1'b1;
                    ent.kind  = wstfu_pkg::KIND_TRUNC;
                end
                else
                begin
                    // Good header with payload still to come: nothing is reported yet.
                    ent_valid = 1'b0;
                end
            end
            else
            begin
                ent_valid = 1'b1;
                ent.data  = rx_byte;
                ent.mask  = mask_byte;
                priority if (is_final)
                begin
                    ent.kind  = wstfu_pkg::KIND_PAYLOAD;
                    ent.last  = 1'b1;
                    done_next = 1'b1;
                end
                else if (buffer_end)
                begin
                    ent.kind = wstfu_pkg::KIND_TRUNC;
                end
                else
                begin
                    ent.kind = wstfu_pkg::KIND_PAYLOAD;
                end
            end

            if (pos_reg != wstfu_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 8'd1;
            end
        end

        // The end of a buffer returns the parser to its starting state.
        if (buffer_end)
        begin
            pos_next    = 8'd0;
            hdr_ok_next = 1'b0;
            len_next    = '0;
            mask_next   = 32'd0;
            done_next   = 1'b0;
        end

        if (!accept)
        begin
            ent_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            hdr_ok_reg <= 1'b0;
            len_reg    <= '0;
            mask_reg   <= 32'd0;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            len_reg    <= len_next;
            mask_reg   <= mask_next;
            done_reg   <= done_next;
        end
    end

    `WSTFU_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && buffer_end,
                       (pos_reg == 8'd0) && !done_reg)
    `WSTFU_ASSERT_SAME(a_done_past_header, clk, rst_n, done_reg,
                       pos_reg >= wstfu_pkg::MIN_BUFFER)
    `WSTFU_ASSERT_SAME(a_last_only_payload, clk, rst_n, ent_valid && ent.last,
                       ent.kind == wstfu_pkg::KIND_PAYLOAD)

endmodule

// ===== src/wstfu_fifo.sv =====
// Short queue that decouples the frame parser from the output stage.
`timescale 1ns / 1ps

module wstfu_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  wstfu_pkg::entry_t wr_data,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_en,
    output wstfu_pkg::entry_t rd_data
);

`include "websocket_text_frame_unmasker_top_assert.svh"

    wstfu_pkg::entry_t                mem_reg [wstfu_pkg::FIFO_DEPTH];
    logic [wstfu_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [wstfu_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [wstfu_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign full     = count_reg == wstfu_pkg::FIFO_CNT_W'(wstfu_pkg::FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `WSTFU_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
                       count_reg <= wstfu_pkg::FIFO_CNT_W'(wstfu_pkg::FIFO_DEPTH))
    `WSTFU_ASSERT_SAME(a_no_overflow, clk, rst_n, wr_en, !full)

endmodule

// ===== src/wstfu_back.sv =====
// Output stage: unmasks the payload byte and holds the result until it is popped.
`timescale 1ns / 1ps

module wstfu_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wstfu_pkg::entry_t in_data,
    output logic              in_take,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        kind,
    output logic [7:0]        payload_byte,
    output logic              frame_last
);

`include "websocket_text_frame_unmasker_top_assert.svh"

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign in_take      = in_valid && (!valid_reg || pop);
    assign empty        = !valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign frame_last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= in_data.kind;
            byte_reg <= in_data.data ^ in_data.mask;
            last_reg <= in_data.last;
        end
    end

    `WSTFU_ASSERT_NEXT(a_hold_when_stalled, clk, rst_n, valid_reg && !pop,
                       valid_reg && $stable(kind_reg) && $stable(byte_reg) && $stable(last_reg))

endmodule

// ===== src/websocket_text_frame_unmasker_top.sv =====
// Top level of the WebSocket text frame unmasker.
`timescale 1ns / 1ps

// The block takes a receive buffer one byte per beat and parses a short-form
// client text frame: header byte, length byte, four mask key bytes, payload.
// Input channel: rx_byte with buffer_end marking the last byte of a buffer;
// a beat is taken when push is high and full is low.
// Result channel: kind, payload_byte and frame_last are valid while empty is
// low, and the beat is taken when pop is high. Payload beats carry the
// unmasked byte; error beats (short buffer, bad header, extended length,
// empty frame, truncated) are reported at most once per buffer, and bytes
// after the end of a frame produce nothing.
// Throughput is one byte per cycle while full is low: the parser handles each
// byte with a position counter and a lane select of the mask key.
// An accepted byte's entry enters the queue at the edge that accepts it, and
// moves on to the output register that drives the ports once that register is free.
// A four-entry queue sits between the parser and the output register, so a
// stalled receiver fills the queue first; full then rises and input stalls.
// Reset clears the parser, empties the queue and drops any held result;
// the first byte after reset starts a new buffer.

module websocket_text_frame_unmasker_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       buffer_end,
    input  logic       push,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] kind,
    output logic [7:0] payload_byte,
    output logic       frame_last
);

    logic              fifo_full;
    logic              ent_valid;
    wstfu_pkg::entry_t ent;
    logic              q_valid;
    logic              q_take;
    wstfu_pkg::entry_t q_data;

    // Parser: one byte per beat, emits a classified entry when a result is due.
    wstfu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .push       (push),
        .full       (full),
        .fifo_full  (fifo_full),
        .ent_valid  (ent_valid),
        .ent        (ent)
    );

    // Decoupling queue.
    wstfu_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (ent_valid),
        .wr_data  (ent),
        .full     (fifo_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_data  (q_data)
    );

    // Output register with the unmasking XOR in front of it.
    wstfu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_data      (q_data),
        .in_take      (q_take),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_last   (frame_last)
    );

endmodule
